FILE: hdl/hlc_pkg.sv
// Shared types, widths and plane helpers for the homogeneous line clipper.
// No dependencies.
`default_nettype none

package hlc_pkg;

	localparam int CW = 32;              // coordinate width
	localparam int TF = 16;              // fraction bits of t
	localparam int DW = CW + 1;          // signed plane distance
	localparam int MW = CW + 1;          // distance magnitude
	localparam int SW = CW + 2;          // sum of magnitudes
	localparam int RW = CW + 3;          // divider remainder
	localparam int DIV_RADIX_BITS = 2;   // quotient bits per divider stage
	localparam int DIV_STAGES = TF / DIV_RADIX_BITS;
	localparam int NUM_PLANES = 6;
	localparam int PLANE_LAT = DIV_STAGES + 5;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] dist_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t w;
	} vec_t;

	typedef struct packed {
		vec_t a;
		vec_t b;
		logic clipped;
		logic discard;
	} seg_t;

	typedef enum logic [2:0] {
		PL_WPZ,
		PL_WMZ,
		PL_WPX,
		PL_WMX,
		PL_WMY,
		PL_WPY
	} plane_t;

	typedef enum logic [1:0] {
		ST_KEPT    = 2'd0,
		ST_CLIPPED = 2'd1,
		ST_DISCARD = 2'd2
	} status_t;

	function automatic dist_t plane_dist(vec_t p, plane_t k);
		dist_t w;
		dist_t c;
		logic  neg;
		w = {p.w[CW-1], p.w};
		c = '0;
		neg = 1'b0;
		case (k)
			PL_WPZ: begin c = {p.z[CW-1], p.z}; neg = 1'b0; end
			PL_WMZ: begin c = {p.z[CW-1], p.z}; neg = 1'b1; end
			PL_WPX: begin c = {p.x[CW-1], p.x}; neg = 1'b0; end
			PL_WMX: begin c = {p.x[CW-1], p.x}; neg = 1'b1; end
			PL_WMY: begin c = {p.y[CW-1], p.y}; neg = 1'b1; end
			PL_WPY: begin c = {p.y[CW-1], p.y}; neg = 1'b0; end
			default: begin c = '0; neg = 1'b0; end
		endcase
		return neg ? (w - c) : (w + c);
	endfunction

	function automatic logic [MW-1:0] dist_mag(dist_t d);
		dist_t n;
		n = -d;
		return d[DW-1] ? MW'(n) : MW'(d);
	endfunction

endpackage

`default_nettype wire

FILE: hdl/hlc_seg_if.sv
// Segment request channel: two clip-space endpoints.
// Depends on hlc_pkg.
`default_nettype none

interface hlc_seg_if;
	import hlc_pkg::*;

	logic   valid;
	logic   ready;
	coord_t a_x;
	coord_t a_y;
	coord_t a_z;
	coord_t a_w;
	coord_t b_x;
	coord_t b_y;
	coord_t b_z;
	coord_t b_w;

	modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, input ready);
	modport sink (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, output ready);
endinterface

`default_nettype wire

FILE: hdl/hlc_res_if.sv
// Result channel: clip status and clipped endpoints.
// Depends on hlc_pkg.
`default_nettype none

interface hlc_res_if;
	import hlc_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] status;
	coord_t     out_a_x;
	coord_t     out_a_y;
	coord_t     out_a_z;
	coord_t     out_a_w;
	coord_t     out_b_x;
	coord_t     out_b_y;
	coord_t     out_b_z;
	coord_t     out_b_w;

	modport source (output valid, status, out_a_x, out_a_y, out_a_z, out_a_w,
		out_b_x, out_b_y, out_b_z, out_b_w, input ready);
	modport sink (input valid, status, out_a_x, out_a_y, out_a_z, out_a_w,
		out_b_x, out_b_y, out_b_z, out_b_w, output ready);
endinterface

`default_nettype wire

FILE: hdl/homogeneous_line_clipper.sv
// Homogeneous frustum line clipper: six plane units in a row (w+z, w-z, w+x, w-x, w-y, w+y).
// Each plane unit is a pipeline of distance, magnitude, 9 divider stages, 2 interpolator.
// Throughput one segment per cycle; the whole pipeline holds while a result waits.
// Each divider stage resolves two quotient bits, which sets the per-plane depth.
// Reset clears only valid bits; the user must not send requests during reset (unenforced).
// Depends on hlc_pkg, hlc_seg_if, hlc_res_if, hlc_plane.
`default_nettype none

module homogeneous_line_clipper (
	input  wire logic clk,
	input  wire logic arst_n,
	hlc_seg_if.sink   seg,
	hlc_res_if.source res
);
	import hlc_pkg::*;

	logic en;
	logic chain_v   [NUM_PLANES+1];
	seg_t chain_seg [NUM_PLANES+1];
	seg_t fin;

	assign en = !res.valid || res.ready;
	assign seg.ready = en;

	assign chain_v[0] = seg.valid;
	assign chain_seg[0].a = '{x: seg.a_x, y: seg.a_y, z: seg.a_z, w: seg.a_w};
	assign chain_seg[0].b = '{x: seg.b_x, y: seg.b_y, z: seg.b_z, w: seg.b_w};
	assign chain_seg[0].clipped = 1'b0;
	assign chain_seg[0].discard = 1'b0;

	for (genvar k = 0; k < NUM_PLANES; k++) begin : g_plane
		hlc_plane u_plane (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.plane     (plane_t'(k)),
			.in_valid  (chain_v[k]),
			.seg_in    (chain_seg[k]),
			.out_valid (chain_v[k+1]),
			.seg_out   (chain_seg[k+1])
		);
	end

	assign fin = chain_seg[NUM_PLANES];
	assign res.valid = chain_v[NUM_PLANES];

	always_comb begin
		if (fin.discard)
			res.status = ST_DISCARD;
		else if (fin.clipped)
			res.status = ST_CLIPPED;
		else
			res.status = ST_KEPT;
	end

	assign res.out_a_x = fin.discard ? '0 : fin.a.x;
	assign res.out_a_y = fin.discard ? '0 : fin.a.y;
	assign res.out_a_z = fin.discard ? '0 : fin.a.z;
	assign res.out_a_w = fin.discard ? '0 : fin.a.w;
	assign res.out_b_x = fin.discard ? '0 : fin.b.x;
	assign res.out_b_y = fin.discard ? '0 : fin.b.y;
	assign res.out_b_z = fin.discard ? '0 : fin.b.z;
	assign res.out_b_w = fin.discard ? '0 : fin.b.w;

endmodule

`default_nettype wire

FILE: hdl/hlc_div.sv
// Pipelined restoring divider for t = m0 / (m0 + m1), unsigned Q0.TF.
// Depends on hlc_pkg.
`default_nettype none

module hlc_div (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [hlc_pkg::MW-1:0] num,
	input  wire logic [hlc_pkg::MW-1:0] m1,
	output logic      [hlc_pkg::TF-1:0] q
);
	import hlc_pkg::*;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [TF-1:0] quo;
	} div_st_t;

	logic [RW-1:0] rem_s [DIV_STAGES+1];
	logic [SW-1:0] den_s [DIV_STAGES+1];
	logic [TF-1:0] quo_s [DIV_STAGES+1];
	logic          sat_s [DIV_STAGES+1];

	function automatic div_st_t div_step(logic [RW-1:0] rem, logic [SW-1:0] den,
		logic [TF-1:0] quo);
		div_st_t r;
		r.rem = rem;
		r.quo = quo;
		for (int j = 0; j < DIV_RADIX_BITS; j++) begin
			r.rem = {r.rem[RW-2:0], 1'b0};
			r.quo = {r.quo[TF-2:0], 1'b0};
			if (r.rem >= RW'(den)) begin
				r.rem = r.rem - RW'(den);
				r.quo[0] = 1'b1;
			end
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= SW'(num) + SW'(m1);
			rem_s[0] <= RW'(num);
			quo_s[0] <= '0;
			// quotient would reach 1.0 only when the far side is exactly on the plane
			sat_s[0] <= (m1 == '0);
			for (int i = 1; i <= DIV_STAGES; i++) begin
				div_st_t st;
				st = div_step(rem_s[i-1], den_s[i-1], quo_s[i-1]);
				rem_s[i] <= st.rem;
				quo_s[i] <= st.quo;
				den_s[i] <= den_s[i-1];
				sat_s[i] <= sat_s[i-1];
			end
		end
	end

	assign q = sat_s[DIV_STAGES] ? '1 : quo_s[DIV_STAGES];

endmodule

`default_nettype wire

FILE: hdl/hlc_lerp.sv
// Two-stage interpolator: p = a + floor((b - a) * t / 2^TF) per component.
// Depends on hlc_pkg.
`default_nettype none

module hlc_lerp (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire hlc_pkg::vec_t          a,
	input  wire hlc_pkg::vec_t          b,
	input  wire logic [hlc_pkg::TF-1:0] t,
	output hlc_pkg::vec_t               p
);
	import hlc_pkg::*;

	localparam int PW = DW + TF + 1;

	typedef logic signed [PW-1:0] prod_t;

	prod_t  prod_s1 [4];
	coord_t base_s1 [4];
	coord_t res_s2  [4];
	coord_t ca [4];
	coord_t cb [4];

	assign ca = '{a.x, a.y, a.z, a.w};
	assign cb = '{b.x, b.y, b.z, b.w};

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				logic signed [DW-1:0] diff;
				logic signed [TF:0]   ts;
				diff = {cb[i][CW-1], cb[i]} - {ca[i][CW-1], ca[i]};
				ts = {1'b0, t};
				prod_s1[i] <= prod_t'(diff) * prod_t'(ts);
				base_s1[i] <= ca[i];
			end
			// bits above TF are the floored step; the sum stays between a and b
			for (int i = 0; i < 4; i++)
				res_s2[i] <= base_s1[i] + prod_s1[i][TF+CW-1:TF];
		end
	end

	assign p.x = res_s2[0];
	assign p.y = res_s2[1];
	assign p.z = res_s2[2];
	assign p.w = res_s2[3];

endmodule

`default_nettype wire

FILE: hdl/hlc_plane.sv
// One clip plane: distance, magnitudes, divider, interpolator, outside endpoint replacement.
// Depends on hlc_pkg, hlc_div, hlc_lerp.
`default_nettype none

module hlc_plane (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire hlc_pkg::plane_t plane,
	input  wire logic            in_valid,
	input  wire hlc_pkg::seg_t   seg_in,
	output logic                 out_valid,
	output hlc_pkg::seg_t        seg_out
);
	import hlc_pkg::*;

	localparam int LAST = PLANE_LAT - 1;
	localparam int LERP_IN = DIV_STAGES + 2;

	seg_t          seg_s  [PLANE_LAT];
	logic          vld_s  [PLANE_LAT];
	logic          clip_s [1:LAST];
	logic          outa_s [1:LAST];
	dist_t         d0_s1;
	dist_t         d1_s1;
	logic [MW-1:0] m0_s2;
	logic [MW-1:0] m1_s2;
	logic [TF-1:0] t;
	vec_t          lp;
	logic          both_out;
	logic          clip;
	seg_t          seg_nxt;

	always_comb begin
		both_out = d0_s1[DW-1] && d1_s1[DW-1];
		clip = !seg_s[0].discard && (d0_s1[DW-1] ^ d1_s1[DW-1]);
		seg_nxt = seg_s[0];
		seg_nxt.discard = seg_s[0].discard || both_out;
		seg_nxt.clipped = seg_s[0].clipped || clip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_LAT; i++)
				vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < PLANE_LAT; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s[0] <= seg_in;
			d0_s1 <= plane_dist(seg_in.a, plane);
			d1_s1 <= plane_dist(seg_in.b, plane);
			seg_s[1] <= seg_nxt;
			clip_s[1] <= clip;
			outa_s[1] <= d0_s1[DW-1];
			m0_s2 <= dist_mag(d0_s1);
			m1_s2 <= dist_mag(d1_s1);
			for (int i = 2; i < PLANE_LAT; i++) begin
				seg_s[i] <= seg_s[i-1];
				clip_s[i] <= clip_s[i-1];
				outa_s[i] <= outa_s[i-1];
			end
		end
	end

	hlc_div u_div (
		.clk (clk),
		.en  (en),
		.num (m0_s2),
		.m1  (m1_s2),
		.q   (t)
	);

	hlc_lerp u_lerp (
		.clk (clk),
		.en  (en),
		.a   (seg_s[LERP_IN].a),
		.b   (seg_s[LERP_IN].b),
		.t   (t),
		.p   (lp)
	);

	// the outside endpoint takes the intersection
	always_comb begin
		seg_out = seg_s[LAST];
		if (clip_s[LAST]) begin
			if (outa_s[LAST])
				seg_out.a = lp;
			else
				seg_out.b = lp;
		end
	end

	assign out_valid = vld_s[LAST];

endmodule

`default_nettype wire

FILE: test/hlc_checker.sv
// Checker for the homogeneous line clipper: watches both channels, predicts each
// result from the accepted segment and compares field by field. Depends on hlc_pkg.
`default_nettype none

module hlc_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic seg_valid,
	input  wire logic seg_ready,
	input  hlc_pkg::coord_t seg_f [8],
	input  wire logic res_valid,
	input  wire logic res_ready,
	input  wire logic [1:0] res_status,
	input  hlc_pkg::coord_t res_f [8],
	output int errors,
	output int pending
);
	import hlc_pkg::*;

	typedef struct {
		status_t st;
		coord_t  c [8];
	} clip_res_t;

	clip_res_t expected_q [$];
	string names [8] = '{"out_a_x", "out_a_y", "out_a_z", "out_a_w",
		"out_b_x", "out_b_y", "out_b_z", "out_b_w"};

	// signed distance to plane k; p = x,y,z,w
	function automatic longint pdist(longint p [4], int k);
		case (k)
			0: return p[3] + p[2];
			1: return p[3] - p[2];
			2: return p[3] + p[0];
			3: return p[3] - p[0];
			4: return p[3] - p[1];
			default: return p[3] + p[1];
		endcase
	endfunction

	function automatic longint t_quot(longint num, longint den);
		longint r, q;
		r = num;
		q = 0;
		if (num >= den)
			return (64'sd1 <<< TF) - 1;
		for (int i = 0; i < TF; i++) begin
			r = r <<< 1;
			q = q <<< 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		return q;
	endfunction

	// exact product fits in 64 bits (diff < 2^33, t < 2^16); >>> floors
	function automatic longint lerp(longint a, longint b, longint t);
		return a + (((b - a) * t) >>> TF);
	endfunction

	function automatic clip_res_t clip_segment(coord_t f [8]);
		clip_res_t r;
		longint pa [4], pb [4], na [4];
		longint d0, d1, t;
		logic cl;
		cl = 1'b0;
		for (int i = 0; i < 4; i++) begin
			pa[i] = f[i];
			pb[i] = f[4+i];
		end
		for (int k = 0; k < NUM_PLANES; k++) begin
			d0 = pdist(pa, k);
			d1 = pdist(pb, k);
			if (d0 < 0 && d1 < 0) begin
				r.st = ST_DISCARD;
				for (int i = 0; i < 8; i++) r.c[i] = '0;
				return r;
			end
			if (d0 < 0 || d1 < 0) begin
				t = t_quot(d0 < 0 ? -d0 : d0, (d0 < 0 ? -d0 : d0) + (d1 < 0 ? -d1 : d1));
				for (int i = 0; i < 4; i++) na[i] = lerp(pa[i], pb[i], t);
				if (d0 >= 0) pb = na;
				else pa = na;
				cl = 1'b1;
			end
		end
		r.st = cl ? ST_CLIPPED : ST_KEPT;
		for (int i = 0; i < 4; i++) begin
			r.c[i] = coord_t'(pa[i]);
			r.c[4+i] = coord_t'(pb[i]);
		end
		return r;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		clip_res_t e;
		if (arst_n) begin
			if (seg_valid && seg_ready)
				expected_q.push_back(clip_segment(seg_f));
			if (res_valid && res_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result, status %0d", res_status);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (res_status !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, res_status);
						errors++;
					end
					for (int i = 0; i < 8; i++)
						if (res_f[i] !== e.c[i]) begin
							$error("%s: expected %0h, got %0h", names[i], e.c[i], res_f[i]);
							errors++;
						end
				end
			end
			pending = expected_q.size();
		end
	end
endmodule

`default_nettype wire

FILE: test/testbench.sv
// Top of the line clipper testbench: clock, reset, segment stimulus, result stalls
// and verdict. Depends on hlc_pkg, hlc_seg_if, hlc_res_if, hlc_checker, the block.
`default_nettype none

module testbench;
	import hlc_pkg::*;

	localparam int LATENCY = 78;
	localparam int N_RANDOM = 1600;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors, pending, idle_cycles;
	coord_t seg_f [8], res_f [8];

	hlc_seg_if seg ();
	hlc_res_if res ();

	homogeneous_line_clipper uut (.clk(clk), .arst_n(arst_n), .seg(seg), .res(res));

	assign seg_f = '{seg.a_x, seg.a_y, seg.a_z, seg.a_w, seg.b_x, seg.b_y, seg.b_z, seg.b_w};
	assign res_f = '{res.out_a_x, res.out_a_y, res.out_a_z, res.out_a_w,
		res.out_b_x, res.out_b_y, res.out_b_z, res.out_b_w};

	hlc_checker chk (.clk(clk), .arst_n(arst_n), .seg_valid(seg.valid), .seg_ready(seg.ready),
		.seg_f(seg_f), .res_valid(res.valid), .res_ready(res.ready), .res_status(res.status),
		.res_f(res_f), .errors(errors), .pending(pending));

	always #10 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// coordinate mix: mostly moderate values so segments cross planes, some extremes
	function automatic coord_t rnd_coord();
		case ($urandom_range(0, 9))
			0: return coord_t'($urandom());
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			2: return coord_t'($urandom_range(0, 8)) - 4;
			default: return coord_t'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
		endcase
	endfunction

	task automatic send_seg(coord_t f [8]);
		repeat (gap_len()) @(negedge clk) seg.valid <= 1'b0;
		@(negedge clk);
		seg.valid <= 1'b1;
		{seg.a_x, seg.a_y, seg.a_z, seg.a_w} <= {f[0], f[1], f[2], f[3]};
		{seg.b_x, seg.b_y, seg.b_z, seg.b_w} <= {f[4], f[5], f[6], f[7]};
		@(posedge clk);
		while (!seg.ready) @(posedge clk);
	endtask

	task automatic send_vals(coord_t ax, ay, az, aw, bx, by, bz, bw);
		coord_t f [8];
		f = '{ax, ay, az, aw, bx, by, bz, bw};
		send_seg(f);
	endtask

	// result side: random stalls, one long hold-off early on
	initial begin
		res.ready = 1'b0;
		@(posedge arst_n);
		repeat (30) @(negedge clk);
		repeat (300) @(negedge clk) res.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (!res.ready && $urandom_range(0, 1)) res.ready <= 1'b1;
			else if (res.ready && $urandom_range(0, 3) == 0) begin
				res.ready <= 1'b0;
				repeat (gap_len()) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((seg.valid && seg.ready) || (res.valid && res.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired");
			$display("** homogeneous_line_clipper: FAILED **");
			$finish;
		end
	end

	initial begin
		coord_t f [8];
		coord_t m;
		idle_cycles = 0;
		seg.valid = 1'b0;
		{seg.a_x, seg.a_y, seg.a_z, seg.a_w, seg.b_x, seg.b_y, seg.b_z, seg.b_w} = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		m = 32'sh00010000;
		// kept, both zero distances, discard, clip at each plane in turn
		send_vals(0, 0, 0, m, m, m, m, 2*m);
		send_vals(0, 0, 0, m, 0, 0, 0, m);
		send_vals(0, 0, 0, 0, 0, 0, 0, 0);
		send_vals(0, 0, -2*m, m, 0, 0, -3*m, m);
		send_vals(0, 0, -2*m, m, 0, 0, 0, m);
		send_vals(0, 0, 0, m, 0, 0, 2*m, m);
		send_vals(-2*m, 0, 0, m, 0, 0, 0, m);
		send_vals(0, 0, 0, m, 3*m, 0, 0, m);
		send_vals(0, 5*m, 0, m, 0, 0, 0, m);
		send_vals(0, 0, 0, m, 0, -7*m, 0, m);
		// endpoints exactly on a plane: t is zero at w+z, no clip at w-z
		send_vals(0, 0, -m, m, 0, 0, -3*m, m);
		send_vals(0, 0, 0, m, 0, 0, m, m);
		// extremes of every field, clipped through several planes or discarded
		send_vals(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		send_vals(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_vals(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_vals(-1, -1, -1, -1, 1, 1, 1, 1);
		send_vals(32'sh7fffffff, -1, 32'sh80000000, 0, -1, 32'sh7fffffff, 0, -1);
		// corner crossings: clipped by several planes
		send_vals(-3*m, -3*m, -3*m, m, 3*m, 3*m, 3*m, m);
		send_vals(5*m, -m, m, 2*m, -5*m, m, -m, 2*m);
		for (int n = 0; n < N_RANDOM; n++) begin
			for (int i = 0; i < 8; i++) f[i] = rnd_coord();
			// w mostly positive so many segments survive early planes
			if ($urandom_range(0, 3) != 0) begin
				f[3] = coord_t'($urandom_range(1, 32'h00200000));
				f[7] = coord_t'($urandom_range(1, 32'h00200000));
			end
			send_seg(f);
		end
		@(negedge clk) seg.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0)
			$display("** homogeneous_line_clipper: PASSED **");
		else
			$display("** homogeneous_line_clipper: FAILED **");
		$finish;
	end
endmodule

`default_nettype wire

FILE: filelist.f
hdl/hlc_pkg.sv
hdl/hlc_seg_if.sv
hdl/hlc_res_if.sv
hdl/hlc_div.sv
hdl/hlc_lerp.sv
hdl/hlc_plane.sv
hdl/homogeneous_line_clipper.sv
test/hlc_checker.sv
test/testbench.sv
